/* hdl/linc_pkg.sv */
// Shared widths, register codes and transfer structures of the linear calibration block.
`default_nettype none

package linc_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_WIDTH    = 32;
   localparam int CFG_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int HALF_WIDTH      = 32;
   localparam int DIFF_WIDTH      = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * HALF_WIDTH + 1;
   localparam int QUO_WIDTH       = 42;
   localparam int VAL_WIDTH       = QUO_WIDTH + 2;

   // Quotients at or above this value lie far outside every output range.
   localparam logic [QUO_WIDTH-1:0] QUO_CAP = {1'b1, {(QUO_WIDTH - 1){1'b0}}};

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RAW_LOW      = 3'd0,
      CSR_RAW_HIGH     = 3'd1,
      CSR_CAL_LOW      = 3'd2,
      CSR_CAL_HIGH     = 3'd3,
      CSR_CLAMP_ENABLE = 3'd4
   } csr_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic signed [CFG_WIDTH-1:0] raw_low;
      logic signed [CFG_WIDTH-1:0] raw_high;
      logic signed [CFG_WIDTH-1:0] cal_low;
      logic signed [CFG_WIDTH-1:0] cal_high;
      logic                        clamp_enable;
   } cfg_type;

   // Partial state of the long division as it moves down the pipeline.
   typedef struct packed {
      logic [DIFF_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0]  dividend;
      logic [QUO_WIDTH-1:0]  quo;
      logic [DIFF_WIDTH-1:0] d_mag;
      logic                  neg;
      logic                  empty;
      logic                  sat;
   } div_state_type;

   // One finished result.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] scaled;
      logic                           empty_range;
      logic                           overflowed;
   } result_type;

endpackage

`default_nettype wire

/* hdl/linc_if.sv */
// Valid/ready channel interfaces for the sample requests and the scaled responses.
`default_nettype none

interface linc_req_if import linc_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface linc_rsp_if import linc_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] scaled;
   logic                           empty_range;
   logic                           overflowed;

   modport source (output valid, output scaled, output empty_range, output overflowed,
                   input ready);
   modport sink   (input valid, input scaled, input empty_range, input overflowed,
                   output ready);
endinterface

`default_nettype wire

/* hdl/linc_front.sv */
// Front pipeline: differences, magnitudes, product and division setup in four stages.
`default_nettype none

module linc_front
   import linc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  cfg_type                        cfg,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   output logic                           out_valid,
   output div_state_type                  out_state
);

   typedef struct packed {
      logic [DIFF_WIDTH-1:0] a_mag;
      logic [DIFF_WIDTH-1:0] b_mag;
      logic [DIFF_WIDTH-1:0] d_mag;
      logic                  sign_odd;
      logic                  empty;
   } prep_type;

   typedef struct packed {
      logic [2*HALF_WIDTH-1:0] low_prod;
      logic                    a_top;
      logic                    b_top;
      logic [HALF_WIDTH-1:0]   a_low;
      logic [HALF_WIDTH-1:0]   b_low;
      logic [DIFF_WIDTH-1:0]   d_mag;
      logic                    neg;
      logic                    empty;
   } mul_type;

   typedef struct packed {
      logic [PROD_WIDTH-1:0] prod;
      logic [DIFF_WIDTH-1:0] d_mag;
      logic                  neg;
      logic                  empty;
   } prod_type;

   function automatic logic [DIFF_WIDTH-1:0] magnitude(input logic [DIFF_WIDTH-1:0] value);
      return value[DIFF_WIDTH-1] ? (~value + DIFF_WIDTH'(1)) : value;
   endfunction

   logic                  prep_valid_ff;
   logic                  mul_valid_ff;
   logic                  prod_valid_ff;
   logic                  div_valid_ff;
   prep_type              prep_ff;
   prep_type              prep_in;
   mul_type               mul_ff;
   mul_type               mul_in;
   prod_type              prod_ff;
   prod_type              prod_in;
   div_state_type         div_ff;
   div_state_type         div_in;
   logic [DIFF_WIDTH-1:0] a_diff;
   logic [DIFF_WIDTH-1:0] b_diff;
   logic [DIFF_WIDTH-1:0] d_diff;
   logic [PROD_WIDTH-QUO_WIDTH-1:0] prod_top;

   // Stage one: the three signed differences, kept as sign and magnitude.
   always_comb begin
      a_diff = {in_sample[SAMPLE_WIDTH-1], in_sample}
             - {cfg.raw_low[CFG_WIDTH-1], cfg.raw_low};
      b_diff = {cfg.cal_high[CFG_WIDTH-1], cfg.cal_high}
             - {cfg.cal_low[CFG_WIDTH-1], cfg.cal_low};
      d_diff = {cfg.raw_high[CFG_WIDTH-1], cfg.raw_high}
             - {cfg.raw_low[CFG_WIDTH-1], cfg.raw_low};
      prep_in.a_mag    = magnitude(a_diff);
      prep_in.b_mag    = magnitude(b_diff);
      prep_in.d_mag    = magnitude(d_diff);
      prep_in.sign_odd = a_diff[DIFF_WIDTH-1] ^ b_diff[DIFF_WIDTH-1] ^ d_diff[DIFF_WIDTH-1];
      prep_in.empty    = (d_diff == '0);
   end

   // Stage two: the low 32 by 32 partial product.
   always_comb begin
      mul_in.low_prod = (2*HALF_WIDTH)'(prep_ff.a_mag[HALF_WIDTH-1:0])
                      * (2*HALF_WIDTH)'(prep_ff.b_mag[HALF_WIDTH-1:0]);
      mul_in.a_top    = prep_ff.a_mag[DIFF_WIDTH-1];
      mul_in.b_top    = prep_ff.b_mag[DIFF_WIDTH-1];
      mul_in.a_low    = prep_ff.a_mag[HALF_WIDTH-1:0];
      mul_in.b_low    = prep_ff.b_mag[HALF_WIDTH-1:0];
      mul_in.d_mag    = prep_ff.d_mag;
      mul_in.neg      = prep_ff.sign_odd && (prep_ff.a_mag != '0) && (prep_ff.b_mag != '0);
      mul_in.empty    = prep_ff.empty;
   end

   // Stage three: fold in the top bits of the magnitudes.
   always_comb begin
      prod_in.prod  = {1'b0, mul_ff.low_prod}
                    + (mul_ff.a_top ? {1'b0, mul_ff.b_low, {HALF_WIDTH{1'b0}}} : '0)
                    + (mul_ff.b_top ? {1'b0, mul_ff.a_low, {HALF_WIDTH{1'b0}}} : '0)
                    + {mul_ff.a_top & mul_ff.b_top, {(2*HALF_WIDTH){1'b0}}};
      prod_in.d_mag = mul_ff.d_mag;
      prod_in.neg   = mul_ff.neg;
      prod_in.empty = mul_ff.empty;
   end

   // Stage four: the upper product bits seed the remainder; a seed at or above
   // the divisor means the quotient is beyond the cap.
   always_comb begin
      prod_top        = prod_ff.prod[PROD_WIDTH-1:QUO_WIDTH];
      div_in.rem      = DIFF_WIDTH'(prod_top);
      div_in.dividend = prod_ff.prod[QUO_WIDTH-1:0];
      div_in.quo      = '0;
      div_in.d_mag    = prod_ff.d_mag;
      div_in.neg      = prod_ff.neg;
      div_in.empty    = prod_ff.empty;
      div_in.sat      = (DIFF_WIDTH'(prod_top) >= prod_ff.d_mag);
   end

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         div_valid_ff  <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= in_valid;
         mul_valid_ff  <= prep_valid_ff;
         prod_valid_ff <= mul_valid_ff;
         div_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff <= prep_in;
         mul_ff  <= mul_in;
         prod_ff <= prod_in;
         div_ff  <= div_in;
      end
   end

   assign out_valid = div_valid_ff;
   assign out_state = div_ff;

endmodule

`default_nettype wire

/* hdl/linc_div_step.sv */
// One restoring division step: one quotient bit per pipeline stage.
`default_nettype none

module linc_div_step
   import linc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  div_state_type in_state,
   output logic          out_valid,
   output div_state_type out_state
);

   logic [DIFF_WIDTH:0]   trial;
   logic [DIFF_WIDTH+1:0] diff;
   logic                  fits;
   logic                  valid_ff;
   div_state_type         state_ff;
   div_state_type         state_in;

   // Bring down the next dividend bit and subtract the divisor if it fits.
   always_comb begin
      trial             = {in_state.rem, in_state.dividend[QUO_WIDTH-1]};
      diff              = {1'b0, trial} - {2'b00, in_state.d_mag};
      fits              = ~diff[DIFF_WIDTH+1];
      state_in          = in_state;
      state_in.rem      = fits ? diff[DIFF_WIDTH-1:0] : trial[DIFF_WIDTH-1:0];
      state_in.dividend = {in_state.dividend[QUO_WIDTH-2:0], 1'b0};
      state_in.quo      = {in_state.quo[QUO_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

`default_nettype wire

/* hdl/linc_back.sv */
// Back pipeline: floor, offset, rounding, clamping and saturation in five stages.
`default_nettype none

module linc_back
   import linc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  cfg_type       cfg,
   input  logic          in_valid,
   input  div_state_type in_state,
   output logic          out_valid,
   output result_type    out_result
);

   localparam logic signed [VAL_WIDTH-1:0] LIM_HI =
      VAL_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [VAL_WIDTH-1:0] LIM_LO = ~LIM_HI;

   typedef struct packed {
      logic signed [QUO_WIDTH:0] qf;
      logic [DIFF_WIDTH-1:0]     rf;
      logic [DIFF_WIDTH-1:0]     d_mag;
      logic                      r_nz;
      logic                      empty;
   } floor_type;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] val;
      logic                        half_ge;
      logic                        half_gt;
      logic                        r_nz;
      logic                        empty;
   } offset_type;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] val;
      logic                        empty;
   } value_type;

   logic                        floor_valid_ff;
   logic                        offset_valid_ff;
   logic                        round_valid_ff;
   logic                        clamp_valid_ff;
   logic                        result_valid_ff;
   floor_type                   floor_ff;
   floor_type                   floor_in;
   offset_type                  offset_ff;
   offset_type                  offset_in;
   value_type                   round_ff;
   value_type                   round_in;
   value_type                   clamp_ff;
   value_type                   clamp_in;
   result_type                  result_ff;
   result_type                  result_in;
   logic [QUO_WIDTH-1:0]        quo_capped;
   logic signed [VAL_WIDTH-1:0] cal_lo_ext;
   logic signed [VAL_WIDTH-1:0] cal_hi_ext;
   logic signed [VAL_WIDTH-1:0] bound_lo;
   logic signed [VAL_WIDTH-1:0] bound_hi;

   // Stage one: cap the quotient and turn truncation into floor division.
   always_comb begin
      quo_capped = (in_state.sat || (in_state.quo > QUO_CAP)) ? QUO_CAP : in_state.quo;
      floor_in.d_mag = in_state.d_mag;
      floor_in.r_nz  = (in_state.rem != '0);
      floor_in.empty = in_state.empty;
      priority if (!in_state.neg) begin
         floor_in.qf = {1'b0, quo_capped};
         floor_in.rf = in_state.rem;
      end else if (in_state.rem == '0) begin
         floor_in.qf = -$signed({1'b0, quo_capped});
         floor_in.rf = in_state.rem;
      end else begin
         floor_in.qf = ~$signed({1'b0, quo_capped});
         floor_in.rf = in_state.d_mag - in_state.rem;
      end
   end

   // Stage two: add the calibrated offset and compare twice the remainder to the divisor.
   always_comb begin
      offset_in.val     = {floor_ff.qf[QUO_WIDTH], floor_ff.qf}
                        + {{(VAL_WIDTH - CFG_WIDTH){cfg.cal_low[CFG_WIDTH-1]}}, cfg.cal_low};
      offset_in.half_ge = ({floor_ff.rf, 1'b0} >= {1'b0, floor_ff.d_mag});
      offset_in.half_gt = ({floor_ff.rf, 1'b0} > {1'b0, floor_ff.d_mag});
      offset_in.r_nz    = floor_ff.r_nz;
      offset_in.empty   = floor_ff.empty;
   end

   // Stage three: halves round away from zero.
   always_comb begin
      round_in.empty = offset_ff.empty;
      if (offset_ff.r_nz && (offset_ff.val[VAL_WIDTH-1] ? offset_ff.half_gt
                                                        : offset_ff.half_ge)) begin
         round_in.val = offset_ff.val + VAL_WIDTH'(1);
      end else begin
         round_in.val = offset_ff.val;
      end
   end

   // Stage four: if enabled, clamp the value to the calibrated range in either direction.
   always_comb begin
      cal_lo_ext = {{(VAL_WIDTH - CFG_WIDTH){cfg.cal_low[CFG_WIDTH-1]}}, cfg.cal_low};
      cal_hi_ext = {{(VAL_WIDTH - CFG_WIDTH){cfg.cal_high[CFG_WIDTH-1]}}, cfg.cal_high};
      if (cfg.cal_low < cfg.cal_high) begin
         bound_lo = cal_lo_ext;
         bound_hi = cal_hi_ext;
      end else begin
         bound_lo = cal_hi_ext;
         bound_hi = cal_lo_ext;
      end
      clamp_in.empty = round_ff.empty;
      priority if (cfg.clamp_enable && (round_ff.val < bound_lo)) begin
         clamp_in.val = bound_lo;
      end else if (cfg.clamp_enable && (round_ff.val > bound_hi)) begin
         clamp_in.val = bound_hi;
      end else begin
         clamp_in.val = round_ff.val;
      end
   end

   // Stage five: saturate to the output width; an empty raw range forces zero.
   always_comb begin
      priority if (clamp_ff.empty) begin
         result_in.scaled      = '0;
         result_in.empty_range = 1'b1;
         result_in.overflowed  = 1'b0;
      end else if (clamp_ff.val > LIM_HI) begin
         result_in.scaled      = LIM_HI[SAMPLE_WIDTH-1:0];
         result_in.empty_range = 1'b0;
         result_in.overflowed  = 1'b1;
      end else if (clamp_ff.val < LIM_LO) begin
         result_in.scaled      = LIM_LO[SAMPLE_WIDTH-1:0];
         result_in.empty_range = 1'b0;
         result_in.overflowed  = 1'b1;
      end else begin
         result_in.scaled      = clamp_ff.val[SAMPLE_WIDTH-1:0];
         result_in.empty_range = 1'b0;
         result_in.overflowed  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_valid_ff  <= 1'b0;
         offset_valid_ff <= 1'b0;
         round_valid_ff  <= 1'b0;
         clamp_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else if (adv) begin
         floor_valid_ff  <= in_valid;
         offset_valid_ff <= floor_valid_ff;
         round_valid_ff  <= offset_valid_ff;
         clamp_valid_ff  <= round_valid_ff;
         result_valid_ff <= clamp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         floor_ff  <= floor_in;
         offset_ff <= offset_in;
         round_ff  <= round_in;
         clamp_ff  <= clamp_in;
         result_ff <= result_in;
      end
   end

   assign out_valid  = result_valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

/* hdl/linear_calibration_clamp.sv */
// Linear range rescale with clamp: a 52-stage pipeline from request transfer to response.
// It holds 4 front stages, 42 division steps, 5 back stages and 1 output register.
// One sample per cycle while the skid register is empty; 42 one-bit steps set the depth.
// A skid register lets a sample transfer while a response waits on a stalled sink.
// Synchronous active-high reset empties the pipeline and loads the default ranges.
`default_nettype none

module linear_calibration_clamp
   import linc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic                       clock,
   input  logic                       reset,
   linc_req_if.sink                   req_chan,
   linc_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data
);

   cfg_type       cfg_ff;
   logic          adv;
   logic          take;
   logic          chain_valid [QUO_WIDTH+1];
   div_state_type chain_state [QUO_WIDTH+1];
   logic          back_valid;
   result_type    back_result;
   logic          out_valid_ff;
   logic          out_valid_in;
   result_type    out_result_ff;
   result_type    out_result_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;
   result_type    skid_result_ff;
   result_type    skid_result_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_low      <= '0;
         cfg_ff.raw_high     <= CFG_WIDTH'(4095);
         cfg_ff.cal_low      <= '0;
         cfg_ff.cal_high     <= CFG_WIDTH'(4095);
         cfg_ff.clamp_enable <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAW_LOW:      cfg_ff.raw_low      <= csr_write_data;
            CSR_RAW_HIGH:     cfg_ff.raw_high     <= csr_write_data;
            CSR_CAL_LOW:      cfg_ff.cal_low      <= csr_write_data;
            CSR_CAL_HIGH:     cfg_ff.cal_high     <= csr_write_data;
            CSR_CLAMP_ENABLE: cfg_ff.clamp_enable <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances while the skid register is free.
   assign adv            = ~skid_valid_ff;
   assign req_chan.ready = adv;

   linc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_sample (req_chan.sample),
      .out_valid (chain_valid[0]),
      .out_state (chain_state[0])
   );

   // Division chain, most significant quotient bit first.
   for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_div
      linc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_state  (chain_state[i]),
         .out_valid (chain_valid[i+1]),
         .out_state (chain_state[i+1])
      );
   end

   linc_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .in_valid   (chain_valid[QUO_WIDTH]),
      .in_state   (chain_state[QUO_WIDTH]),
      .out_valid  (back_valid),
      .out_result (back_result)
   );

   // Output register with a skid entry behind it.
   assign take = out_valid_ff & rsp_chan.ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_result_in  = out_result_ff;
      skid_valid_in  = skid_valid_ff;
      skid_result_in = skid_result_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in  = back_valid;
         out_result_in = back_result;
      end else if (back_valid) begin
         skid_valid_in  = 1'b1;
         skid_result_in = back_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_result_ff  <= out_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.scaled      = out_result_ff.scaled;
   assign rsp_chan.empty_range = out_result_ff.empty_range;
   assign rsp_chan.overflowed  = out_result_ff.overflowed;

endmodule

`default_nettype wire

/* hdl/linc_checker.sv */
// Port-level assertions for the calibration block and the bind that attaches them.
`default_nettype none

module linc_checker
   import linc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_scaled,
   input logic                           rsp_empty_range,
   input logic                           rsp_overflowed
);

   localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX =
      SAMPLE_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled)
         && $stable(rsp_empty_range) && $stable(rsp_overflowed))
      else $error("stalled response changed");

   // Requests are refused only while a response has been waiting.
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("request ready dropped without a stalled response");

   // An empty raw range always reports zero and no overflow.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_range |-> rsp_scaled == '0 && !rsp_overflowed)
      else $error("empty range response is not zero");

   // A saturated response sits exactly on one limit of the output width.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_scaled == SAT_MAX || rsp_scaled == SAT_MIN)
      else $error("overflowed response is not at a limit");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind linear_calibration_clamp linc_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_scaled      (rsp_chan.scaled),
   .rsp_empty_range (rsp_chan.empty_range),
   .rsp_overflowed  (rsp_chan.overflowed)
);

`default_nettype wire
